FILE: rtl/core/guillotine_atlas_packer_defines.svh
// Assertion macros for the guillotine atlas packer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GUILLOTINE_ATLAS_PACKER_DEFINES_SVH
`define GUILLOTINE_ATLAS_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is held
`define GAP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define GAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define GAP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define GAP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/gap_pkg.sv
// Shared types and constants for the guillotine atlas packer.
// Used by gap_free_ram and guillotine_atlas_packer; no dependencies.
`timescale 1ns / 1ps

package gap_pkg;

    // Sizing
    localparam int FREE_SLOTS = 64;
    localparam int DIM_BITS   = 15;
    localparam int INDEX_BITS = 16;
    localparam int SLOT_BITS  = $clog2(FREE_SLOTS);
    localparam int CNT_BITS   = $clog2(FREE_SLOTS + 1);

    // Fixed widths of the stream fields
    localparam int POS_OUT_BITS = 14;
    localparam int IDX_OUT_BITS = 16;

    // Atlas size after reset
    localparam logic [DIM_BITS-1:0] ATLAS_RST = DIM_BITS'(1024);

    // One free rectangle
    typedef struct packed {
        logic [DIM_BITS-1:0] x;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } t_rect;

    localparam t_rect RECT_RST = '{x: '0, y: '0, w: ATLAS_RST, h: ATLAS_RST};

    // Write port of the free list memory
    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        t_rect                data;
    } t_wr_port;

    typedef enum logic [1:0] {
        OP_TILESET = 2'd0,
        OP_SHEET   = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SHIFT,
        S_APP0,
        S_APP1,
        S_RESP
    } t_state;

endpackage

FILE: rtl/core/gap_free_ram.sv
// Free rectangle list storage: one write port, one registered read port.
// Entry 0 reads as the reset atlas until first written. Depends on gap_pkg.
`timescale 1ns / 1ps

module gap_free_ram
    import gap_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_wr_port             i_wr,
    input  logic [SLOT_BITS-1:0] i_rd_addr,
    output t_rect                o_rd_data
);

    t_rect mem [FREE_SLOTS];
    t_rect r_q;
    logic  r_e0_rst;
    logic  r_hit_rst;

    // Storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= mem[i_rd_addr];
    end

    // Entry 0 holds the reset rectangle until something lands there
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_rst  <= 1'b1;
            r_hit_rst <= 1'b0;
        end else begin
            if (i_wr.en && i_wr.addr == '0) begin
                r_e0_rst <= 1'b0;
            end
            r_hit_rst <= r_e0_rst && (i_rd_addr == '0);
        end
    end

    assign o_rd_data = r_hit_rst ? RECT_RST : r_q;

endmodule

FILE: rtl/core/guillotine_atlas_packer.sv
// Guillotine atlas packer, first fit, over a free list held in one RAM.
// A clear, a rejected op or a zero-sized request goes from the idle state
// straight to the response step. A place request scans the list in order,
// one RAM read per cycle, up to the first hit; the evaluate step sizes the
// remainders, the entries behind the hit move down one slot a cycle through
// the single read and write port, the append steps S_APP0 and S_APP1 write
// the remainders and the response step hands the word to the output register.
// A new word is taken while the previous result still waits on the output.
// No clearing pass is needed after reset; atlas size writes take effect at
// the next clear.
`timescale 1ns / 1ps
`include "guillotine_atlas_packer_defines.svh"

module guillotine_atlas_packer
    import gap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [14:0] i_cfg_wr_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // req_width [14:0], req_height [29:15], zero [31:30]
    input  logic [1:0]  i_s_tuser,   // op [1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // place_x [13:0], place_y [27:14], item_index [43:28]
    output logic [1:0]  o_m_tuser    // status [1:0]
);

    t_state                  r_state, n_state;
    logic [CNT_BITS-1:0]     r_count, n_count;
    logic [INDEX_BITS-1:0]   r_tile_cnt, n_tile_cnt;
    logic [INDEX_BITS-1:0]   r_sheet_cnt, n_sheet_cnt;
    logic [DIM_BITS-1:0]     r_atlas_w, r_atlas_h;
    logic                    r_out_valid, n_out_valid;

    logic [SLOT_BITS-1:0]    r_chk, n_chk;
    logic [SLOT_BITS-1:0]    r_dst, n_dst;
    logic                    r_sheet, n_sheet;
    logic [DIM_BITS-1:0]     r_rw, n_rw;
    logic [DIM_BITS-1:0]     r_rh, n_rh;
    t_rect                   r_rect, n_rect;
    t_rect                   r_part0, n_part0;
    t_rect                   r_part1, n_part1;
    logic [1:0]              r_nparts, n_nparts;

    t_status                 r_res_status, n_res_status;
    logic [POS_OUT_BITS-1:0] r_res_x, n_res_x;
    logic [POS_OUT_BITS-1:0] r_res_y, n_res_y;
    logic [IDX_OUT_BITS-1:0] r_res_idx, n_res_idx;

    t_status                 r_out_status, n_out_status;
    logic [POS_OUT_BITS-1:0] r_out_x, n_out_x;
    logic [POS_OUT_BITS-1:0] r_out_y, n_out_y;
    logic [IDX_OUT_BITS-1:0] r_out_idx, n_out_idx;

    t_wr_port                wr;
    logic [SLOT_BITS-1:0]    rd_addr;
    t_rect                   rd_data;

    logic                    s_acc;
    logic [DIM_BITS-1:0]     in_rw, in_rh;
    logic                    fit;
    logic                    has_right, has_bottom;
    t_rect                   right_r, bottom_r;
    logic [1:0]              eval_n;
    logic [CNT_BITS:0]       need_slots;

    gap_free_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_rw      = DIM_BITS'(i_s_tdata[14:0]);
    assign in_rh      = DIM_BITS'(i_s_tdata[29:15]);

    // Fit test on the entry coming out of the RAM
    assign fit = (r_rw <= rd_data.w) && (r_rh <= rd_data.h);

    // Remainders of the chosen rectangle
    assign has_right  = r_rw < r_rect.w;
    assign has_bottom = r_rh < r_rect.h;
    assign right_r    = '{x: r_rect.x + r_rw, y: r_rect.y, w: r_rect.w - r_rw, h: r_rh};
    assign bottom_r   = '{x: r_rect.x, y: r_rect.y + r_rh, w: r_rect.w, h: r_rect.h - r_rh};
    assign eval_n     = {1'b0, has_right} + {1'b0, has_bottom};
    assign need_slots = (CNT_BITS+1)'(r_count) - (CNT_BITS+1)'(1) + (CNT_BITS+1)'(eval_n);

    // Atlas size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= ATLAS_RST;
            r_atlas_h <= ATLAS_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:  r_atlas_w <= DIM_BITS'(i_cfg_wr_data);
                CFG_HEIGHT: r_atlas_h <= DIM_BITS'(i_cfg_wr_data);
                default:    ;
            endcase
        end
    end

    // Sequencer: next state, RAM access and datapath updates
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_tile_cnt   = r_tile_cnt;
        n_sheet_cnt  = r_sheet_cnt;
        n_out_valid  = r_out_valid;
        n_chk        = r_chk;
        n_dst        = r_dst;
        n_sheet      = r_sheet;
        n_rw         = r_rw;
        n_rh         = r_rh;
        n_rect       = r_rect;
        n_part0      = r_part0;
        n_part1      = r_part1;
        n_nparts     = r_nparts;
        n_res_status = r_res_status;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_idx    = r_res_idx;
        n_out_status = r_out_status;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_idx    = r_out_idx;
        wr           = '0;
        rd_addr      = r_chk + SLOT_BITS'(1);

        // output register drains independently
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (s_acc) begin
                    n_sheet      = (i_s_tuser == OP_SHEET);
                    n_rw         = in_rw;
                    n_rh         = in_rh;
                    n_res_status = ST_NOFIT;
                    n_res_x      = '0;
                    n_res_y      = '0;
                    n_res_idx    = '0;
                    n_chk        = '0;
                    n_state      = S_RESP;
                    case (t_op'(i_s_tuser))
                        OP_CLEAR: begin
                            wr.en        = 1'b1;
                            wr.addr      = '0;
                            wr.data      = '{x: '0, y: '0, w: r_atlas_w, h: r_atlas_h};
                            n_count      = CNT_BITS'(1);
                            n_res_status = ST_OK;
                        end
                        OP_TILESET, OP_SHEET: begin
                            if (in_rw != '0 && in_rh != '0 && r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // one entry checked per cycle, next read issued alongside
            S_SCAN: begin
                if (fit) begin
                    n_rect  = rd_data;
                    n_state = S_EVAL;
                end else if (CNT_BITS'(r_chk) + CNT_BITS'(1) == r_count) begin
                    n_state = S_RESP;
                end else begin
                    n_chk = r_chk + SLOT_BITS'(1);
                end
            end

            S_EVAL: begin
                if (need_slots > (CNT_BITS+1)'(FREE_SLOTS)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_RESP;
                end else begin
                    n_part0  = has_right ? right_r : bottom_r;
                    n_part1  = bottom_r;
                    n_nparts = eval_n;
                    n_dst    = r_chk;
                    rd_addr  = r_chk + SLOT_BITS'(1);
                    if (CNT_BITS'(r_chk) + CNT_BITS'(1) < r_count) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_APP0;
                    end
                end
            end

            // close the gap: entry dst+1 moves to dst
            S_SHIFT: begin
                wr.en   = 1'b1;
                wr.addr = r_dst;
                wr.data = rd_data;
                rd_addr = r_dst + SLOT_BITS'(2);
                if (CNT_BITS'(r_dst) + CNT_BITS'(2) == r_count) begin
                    n_state = S_APP0;
                end else begin
                    n_dst = r_dst + SLOT_BITS'(1);
                end
            end

            S_APP0: begin
                if (r_nparts != 2'd0) begin
                    wr.en   = 1'b1;
                    wr.addr = SLOT_BITS'(r_count - CNT_BITS'(1));
                    wr.data = r_part0;
                end
                n_state = S_APP1;
            end

            S_APP1: begin
                if (r_nparts == 2'd2) begin
                    wr.en   = 1'b1;
                    wr.addr = SLOT_BITS'(r_count);
                    wr.data = r_part1;
                end
                n_count      = r_count - CNT_BITS'(1) + CNT_BITS'(r_nparts);
                n_res_status = ST_OK;
                n_res_x      = POS_OUT_BITS'(r_rect.x);
                n_res_y      = POS_OUT_BITS'(r_rect.y);
                if (r_sheet) begin
                    n_res_idx   = IDX_OUT_BITS'(r_sheet_cnt);
                    n_sheet_cnt = r_sheet_cnt + INDEX_BITS'(1);
                end else begin
                    n_res_idx  = IDX_OUT_BITS'(r_tile_cnt);
                    n_tile_cnt = r_tile_cnt + INDEX_BITS'(1);
                end
                n_state = S_RESP;
            end

            // hand the result to the output register once it is free
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_x      = r_res_x;
                    n_out_y      = r_res_y;
                    n_out_idx    = r_res_idx;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_BITS'(1);
            r_tile_cnt  <= '0;
            r_sheet_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tile_cnt  <= n_tile_cnt;
            r_sheet_cnt <= n_sheet_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_chk        <= n_chk;
        r_dst        <= n_dst;
        r_sheet      <= n_sheet;
        r_rw         <= n_rw;
        r_rh         <= n_rh;
        r_rect       <= n_rect;
        r_part0      <= n_part0;
        r_part1      <= n_part1;
        r_nparts     <= n_nparts;
        r_res_status <= n_res_status;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_idx    <= n_res_idx;
        r_out_status <= n_out_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_idx    <= n_out_idx;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'b0, r_out_idx, r_out_y, r_out_x};

    // Checks
    `GAP_ASSERT_CLK(a_count_range, i_clk, i_rst_n,
                    r_count <= CNT_BITS'(FREE_SLOTS), "free count beyond slots")
    `GAP_ASSERT_CLK(a_clear_count, i_clk, i_rst_n,
                    (s_acc && i_s_tuser == OP_CLEAR) |=> (r_count == CNT_BITS'(1)),
                    "clear did not restore one free entry")
    `GAP_ASSERT_CLK(a_out_from_resp, i_clk, i_rst_n,
                    $rose(o_m_tvalid) |-> $past(r_state == S_RESP),
                    "result shown outside response step")
    `GAP_ASSERT_CLK(a_shift_bound, i_clk, i_rst_n,
                    (r_state == S_SHIFT) |-> (CNT_BITS'(r_dst) + CNT_BITS'(2) <= r_count),
                    "shift ran past the list end")

endmodule

FILE: test/guillotine_atlas_packer_tb.sv
// Self-checking testbench for guillotine_atlas_packer: streams place and clear requests,
// predicts every result word with a first-fit free-list model and checks each field.
// Depends on gap_pkg and the packer RTL only.
`timescale 1ns / 1ps

module guillotine_atlas_packer_tb;
    import gap_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_PCT        = 12;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int LADDER_LEN      = 70;
    localparam int MAX_FIELD       = 32767;

    // op code with no meaning, answered as a miss
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } pack_req_t;

    typedef struct packed {
        t_status                 status;
        logic [POS_OUT_BITS-1:0] x;
        logic [POS_OUT_BITS-1:0] y;
        logic [IDX_OUT_BITS-1:0] idx;
    } placement_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_addr    = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    // model of the free list
    t_rect                 free_list [FREE_SLOTS];
    int                    free_cnt;
    int                    free_cnt_peak;
    logic [INDEX_BITS-1:0] tileset_cnt;
    logic [INDEX_BITS-1:0] sheet_cnt;
    logic [DIM_BITS-1:0]   atlas_w;
    logic [DIM_BITS-1:0]   atlas_h;

    pack_req_t  req_q [$];
    pack_req_t  tx_req;
    placement_t placement_expect_q [$];

    bit          no_idle      = 1'b0;
    int unsigned rx_hold_reqs = 0;
    int unsigned rx_hold_seen = 0;
    int unsigned rx_hold_left = 0;
    int unsigned stall_cycles = 0;
    int unsigned fail_cnt     = 0;
    int unsigned queued_items = 0;
    int unsigned n_placed     = 0;
    int unsigned n_nofit      = 0;
    int unsigned n_full       = 0;
    int unsigned n_clears     = 0;
    int unsigned n_checked    = 0;

    guillotine_atlas_packer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void clear_free_list();
        free_list[0] = '{x: '0, y: '0, w: atlas_w, h: atlas_h};
        free_cnt = 1;
    endfunction

    // First fit: take the first free rect the request fits, split off right and bottom parts
    function automatic placement_t predict_placement(input pack_req_t req);
        placement_t res;
        t_rect      hit_rect;
        t_rect      parts [2];
        int         hit_at;
        int         n_parts;
        int         i;
        res = '{status: ST_OK, x: '0, y: '0, idx: '0};
        hit_at = -1;
        n_parts = 0;
        if (req.op == OP_CLEAR) begin
            clear_free_list();
            n_clears++;
            return res;
        end
        if (req.op == OP_UNUSED || req.w == 0 || req.h == 0) begin
            res.status = ST_NOFIT;
            n_nofit++;
            return res;
        end
        for (i = 0; i < free_cnt; i++) begin
            if (hit_at < 0 && req.w <= free_list[i].w && req.h <= free_list[i].h)
                hit_at = i;
        end
        if (hit_at < 0) begin
            res.status = ST_NOFIT;
            n_nofit++;
            return res;
        end
        hit_rect = free_list[hit_at];
        if (req.w < hit_rect.w) begin
            parts[n_parts] = '{x: hit_rect.x + req.w, y: hit_rect.y,
                               w: hit_rect.w - req.w, h: req.h};
            n_parts++;
        end
        if (req.h < hit_rect.h) begin
            parts[n_parts] = '{x: hit_rect.x, y: hit_rect.y + req.h,
                               w: hit_rect.w, h: hit_rect.h - req.h};
            n_parts++;
        end
        if (free_cnt - 1 + n_parts > FREE_SLOTS) begin
            res.status = ST_FULL;
            n_full++;
            return res;
        end
        // remove the hit entry keeping order, then append the parts
        for (i = hit_at; i < free_cnt - 1; i++)
            free_list[i] = free_list[i + 1];
        free_cnt--;
        for (i = 0; i < n_parts; i++) begin
            free_list[free_cnt] = parts[i];
            free_cnt++;
        end
        if (free_cnt > free_cnt_peak)
            free_cnt_peak = free_cnt;
        if (req.op == OP_TILESET) begin
            res.idx = tileset_cnt[IDX_OUT_BITS-1:0];
            tileset_cnt++;
        end else begin
            res.idx = sheet_cnt[IDX_OUT_BITS-1:0];
            sheet_cnt++;
        end
        res.x = hit_rect.x[POS_OUT_BITS-1:0];
        res.y = hit_rect.y[POS_OUT_BITS-1:0];
        n_placed++;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_cnt++;
        end
    endfunction

    function automatic void add_req(input logic [1:0] op, input int unsigned w,
                                    input int unsigned h);
        pack_req_t item;
        item = '{op: op, w: DIM_BITS'(w), h: DIM_BITS'(h)};
        req_q = {req_q, item};
        queued_items++;
    endfunction

    // mostly small sizes, some up to the whole atlas
    function automatic int unsigned pick_dim(input int unsigned a);
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 5)
            return $urandom_range(1, (a / 8 > 1) ? a / 8 : 1);
        else if (roll < 8)
            return $urandom_range(1, (a / 2 > 1) ? a / 2 : 1);
        return $urandom_range(1, (a > 1) ? a : 1);
    endfunction

    // Strictly taller requests skip every right part and split the bottom one,
    // so the list grows by one per word until it overflows.
    function automatic void add_ladder(input int unsigned aw);
        int unsigned h;
        int unsigned w_top;
        h = 0;
        w_top = (aw - 1 < 4000) ? aw - 1 : 4000;
        add_req(OP_CLEAR, $urandom_range(MAX_FIELD), $urandom_range(MAX_FIELD));
        repeat (LADDER_LEN) begin
            h += $urandom_range(1, 2);
            add_req(2'($urandom_range(1)), $urandom_range(1, w_top), h);
        end
    endfunction

    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || placement_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers back to back, enable held high across the two words
    task automatic set_atlas(input logic [14:0] w, input logic [14:0] h);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_WIDTH;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_addr    <= CFG_HEIGHT;
        cfg_wr_data <= h;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        atlas_w = w;
        atlas_h = h;
    endtask

    // Request driver: predicts each word as it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                placement_expect_q = {placement_expect_q, predict_placement(tx_req)};
            if (!s_tvalid || s_tready) begin
                if (req_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    tx_req = req_q.pop_front();
                    s_tdata  <= {2'b00, tx_req.h, tx_req.w};
                    s_tuser  <= tx_req.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure plus one long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_left == 0 && rx_hold_seen != rx_hold_reqs) begin
                rx_hold_seen = rx_hold_reqs;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin
        placement_t exp_res;
        if (rst_n && m_tvalid && m_tready) begin
            if (placement_expect_q.size() == 0) begin
                $error("result word with no request outstanding: status %0d", m_tuser);
                fail_cnt++;
            end else begin
                exp_res = placement_expect_q.pop_front();
                check_field("status", exp_res.status, m_tuser);
                check_field("place_x", exp_res.x, m_tdata[13:0]);
                check_field("place_y", exp_res.y, m_tdata[27:14]);
                check_field("item_index", exp_res.idx, m_tdata[43:28]);
                n_checked++;
            end
        end
    end

    // Watchdog: no handshake on either side while work is owed
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (req_q.size() == 0 && !s_tvalid && placement_expect_q.size() == 0))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results owed",
                         stall_cycles, placement_expect_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int unsigned aw;
        int unsigned ah;
        int unsigned start_cnt;
        int unsigned roll;
        atlas_w = ATLAS_RST;
        atlas_h = ATLAS_RST;
        tileset_cnt = '0;
        sheet_cnt = '0;
        clear_free_list();
        free_cnt_peak = 1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: exact fits, misses, zero sizes, unused op, field extremes
        add_req(OP_TILESET, 1024, 1024);
        add_req(OP_SHEET, 1, 1);
        add_req(OP_CLEAR, 0, 0);
        add_req(OP_UNUSED, 10, 10);
        add_req(OP_TILESET, 0, 5);
        add_req(OP_TILESET, 5, 0);
        add_req(OP_SHEET, MAX_FIELD, MAX_FIELD);
        add_req(OP_TILESET, 1025, 1);
        add_req(OP_SHEET, 1, 1);
        add_req(OP_TILESET, 1023, 1);
        add_req(OP_TILESET, 1024, 1);
        add_req(OP_SHEET, 100, 1022);
        add_req(OP_SHEET, 924, 1022);
        add_req(OP_TILESET, 1, 1);
        add_req(OP_CLEAR, MAX_FIELD, MAX_FIELD);
        add_req(OP_UNUSED, 0, 0);
        add_req(OP_TILESET, 16384, 16384);
        add_req(OP_TILESET, 1024, 1024);
        wait_drained();

        // zero-width atlas: nothing fits after the clear
        set_atlas(15'd0, 15'd16384);
        add_req(OP_CLEAR, 0, 0);
        add_req(OP_TILESET, 1, 1);
        add_req(OP_SHEET, 16384, 1);
        wait_drained();

        // largest field values: coordinates past 14 bits come back masked
        set_atlas(15'd32767, 15'd32767);
        add_req(OP_CLEAR, 0, 0);
        add_req(OP_TILESET, 20000, 20000);
        add_req(OP_TILESET, 100, 100);
        add_req(OP_SHEET, 32767, 12767);
        wait_drained();

        // Random phases, one atlas size each
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin aw = 1024;  ah = 1024;  end
                1: begin aw = 16384; ah = 16384; end
                2: begin aw = 1;     ah = 1;     end
                3: begin aw = 16;    ah = 8;     end
                4: begin aw = $urandom_range(1, 16384); ah = $urandom_range(1, 16384); end
                5: begin aw = 300;   ah = 16384; end
                default: begin aw = 16384; ah = 1; end
            endcase
            set_atlas(aw[14:0], ah[14:0]);
            no_idle <= (p == 1);
            start_cnt = queued_items;
            add_req(OP_CLEAR, $urandom_range(MAX_FIELD), $urandom_range(MAX_FIELD));
            if (aw >= 2 && ah >= 6000)
                add_ladder(aw);
            while (queued_items - start_cnt < ITEMS_PER_PHASE) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    add_req(OP_CLEAR, $urandom_range(MAX_FIELD), $urandom_range(MAX_FIELD));
                end else if (roll < 10) begin
                    add_req(2'($urandom_range(3)),
                            ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_FIELD),
                            ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_FIELD));
                end else if (roll < 11 && aw >= 2 && ah >= 6000) begin
                    add_ladder(aw);
                end else begin
                    add_req(2'($urandom_range(1)), pick_dim(aw), pick_dim(ah));
                end
            end
            // long receiver hold while the sender keeps offering
            if (p == 0)
                rx_hold_reqs <= rx_hold_reqs + 1;
            wait_drained();
        end
        no_idle <= 1'b0;

        $display("Checked %0d result words: %0d placed, %0d misses, %0d list-full, %0d clears",
                 n_checked, n_placed, n_nofit, n_full, n_clears);
        $display("Atlas sizes from empty to 32767 square; free list peaked at %0d entries",
                 free_cnt_peak);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
